>>> design/rcc_pkg.sv
`default_nettype none
package rcc_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W = 52;
   localparam int RIDGE_W = 40;
   localparam int CNT_W = 21;
   localparam int COEF_W = 32;
   localparam int CORR_W = 16;

   // Width of the shared adder. It holds m*m*sxx*syy for a 16-bit m.
   localparam int WIDE_W = 137;

   // Restoring division of (|sxy| << 16) by the ridge denominator.
   localparam int DIV_STEPS = SUM_W + 16;
   // Shift-and-add multiplication over one 52-bit operand.
   localparam int MUL_STEPS = SUM_W;
   // Bits of the correlation magnitude found by the root search.
   localparam int ROOT_BITS = 16;

   localparam int MAX_SERIES_LOG2_DEF = 20;

   typedef struct packed {
      logic signed [SUM_W-1:0] sxy;
      logic [SUM_W-1:0] sxx;
      logic [SUM_W-1:0] syy;
      logic [CNT_W-1:0] cnt;
      logic ovf;
   } rcc_sums_type;

   typedef enum logic [1:0] {
      TS_IDLE,
      TS_ACCUM,
      TS_SOLVE
   } rcc_top_state_type;

   typedef enum logic [3:0] {
      SV_IDLE,
      SV_DEN,
      SV_DIV,
      SV_COEF,
      SV_MULP,
      SV_MULR,
      SV_ADDD,
      SV_ADDP,
      SV_CMP,
      SV_UPD,
      SV_FIN,
      SV_DONE
   } rcc_solve_state_type;

endpackage
`default_nettype wire

>>> design/ridge_coeff_and_correlation_core.sv
// A request with a nonzero independent sample goes through the accumulator before the
// input is free again; one with a zero independent sample adds nothing to the sums. A last
// request then goes through the solver, and its response shows once the result is loaded,
// or later if the response is stalled. Only one request is in work at a time, so a last
// request blocks the input until its result is loaded. The division and root search share one
// 137-bit adder. Reset is synchronous, active high, and clears sums, count, ridge and control.
`default_nettype none
module ridge_coeff_and_correlation_core #(
   parameter int MAX_SERIES_LOG2 = rcc_pkg::MAX_SERIES_LOG2_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rcc_pkg::SAMPLE_W-1:0] req_dep_sample,
   input  logic signed [rcc_pkg::SAMPLE_W-1:0] req_indep_sample,
   input  logic                                req_last_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rcc_pkg::COEF_W-1:0]   rsp_coefficient,
   output logic signed [rcc_pkg::CORR_W-1:0]   rsp_correlation,
   output logic [rcc_pkg::CNT_W-1:0]           rsp_pairs_used,
   output logic                                rsp_saturated,
   input  logic                                csr_wr_en,
   input  logic [rcc_pkg::RIDGE_W-1:0]         csr_wr_data
);

   rcc_pkg::rcc_top_state_type state_ff, state_in;

   logic [rcc_pkg::RIDGE_W-1:0] ridge_ff, ridge_in;
   logic last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [rcc_pkg::COEF_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic signed [rcc_pkg::CORR_W-1:0] rsp_corr_ff, rsp_corr_in;
   logic [rcc_pkg::CNT_W-1:0] rsp_pairs_ff, rsp_pairs_in;
   logic rsp_sat_ff, rsp_sat_in;

   logic accept;
   logic indep_zero;
   logic accum_start, accum_done, accum_clear;
   logic solve_start, solve_done, load;
   rcc_pkg::rcc_sums_type sums;
   logic signed [rcc_pkg::COEF_W-1:0] solve_coef;
   logic signed [rcc_pkg::CORR_W-1:0] solve_corr;
   logic solve_sat;

   // The accumulator updates the three saturating sums with one shared multiplier.
   rcc_accum #(
      .MAX_SERIES_LOG2 (MAX_SERIES_LOG2)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .start        (accum_start),
      .clear        (accum_clear),
      .dep_sample   (req_dep_sample),
      .indep_sample (req_indep_sample),
      .done         (accum_done),
      .sums         (sums)
   );

   // The solver works out the ridge slope and the correlation from the finished sums.
   rcc_solve u_solve (
      .clock       (clock),
      .reset       (reset),
      .start       (solve_start),
      .ack         (load),
      .sums        (sums),
      .ridge       (ridge_ff),
      .done        (solve_done),
      .coefficient (solve_coef),
      .correlation (solve_corr),
      .out_sat     (solve_sat)
   );

   assign req_stall = (state_ff != rcc_pkg::TS_IDLE);
   assign accept = req_valid && !req_stall;
   assign indep_zero = (req_indep_sample == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcc_pkg::TS_IDLE: begin
            if (accept) begin
               if (!indep_zero) begin
                  state_in = rcc_pkg::TS_ACCUM;
               end else if (req_last_sample) begin
                  state_in = rcc_pkg::TS_SOLVE;
               end
            end
         end
         rcc_pkg::TS_ACCUM: begin
            if (accum_done) begin
               state_in = last_ff ? rcc_pkg::TS_SOLVE : rcc_pkg::TS_IDLE;
            end
         end
         rcc_pkg::TS_SOLVE: if (load) state_in = rcc_pkg::TS_IDLE;
         default: state_in = rcc_pkg::TS_IDLE;
      endcase
   end

   // Control outputs. A finished result is loaded only once the response register
   // is empty or its current response is being taken; the sums are cleared then.
   always_comb begin
      accum_start = 1'b0;
      solve_start = 1'b0;
      load = 1'b0;
      case (state_ff)
         rcc_pkg::TS_IDLE: begin
            accum_start = accept && !indep_zero;
            solve_start = accept && indep_zero && req_last_sample;
         end
         rcc_pkg::TS_ACCUM: solve_start = accum_done && last_ff;
         rcc_pkg::TS_SOLVE: load = solve_done && (!rsp_valid_ff || !rsp_stall);
         default: begin
         end
      endcase
      accum_clear = load;
   end

   always_comb begin
      ridge_in = csr_wr_en ? csr_wr_data : ridge_ff;
      last_in = accept ? req_last_sample : last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_coef_in = rsp_coef_ff;
      rsp_corr_in = rsp_corr_ff;
      rsp_pairs_in = rsp_pairs_ff;
      rsp_sat_in = rsp_sat_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_coef_in = solve_coef;
         rsp_corr_in = solve_corr;
         rsp_pairs_in = sums.cnt;
         rsp_sat_in = sums.ovf | solve_sat;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      rsp_coef_ff <= rsp_coef_in;
      rsp_corr_ff <= rsp_corr_in;
      rsp_pairs_ff <= rsp_pairs_in;
      rsp_sat_ff <= rsp_sat_in;
      if (reset) begin
         state_ff <= rcc_pkg::TS_IDLE;
         ridge_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ridge_ff <= ridge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_coefficient = rsp_coef_ff;
   assign rsp_correlation = rsp_corr_ff;
   assign rsp_pairs_used = rsp_pairs_ff;
   assign rsp_saturated = rsp_sat_ff;

   // A request that starts work keeps the input side stalled in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (!indep_zero || req_last_sample)) |=> req_stall)
      else $error("input not stalled while a request is in work");

   // The sums must not move while the solver reads them.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == rcc_pkg::TS_SOLVE) && $past(state_ff == rcc_pkg::TS_SOLVE)
       && !$past(load)) |-> $stable(sums))
      else $error("sums changed during the final computation");

   // A new response only appears after a solve.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(load))
      else $error("response shown without a finished computation");

   // The solver is started only from idle or in the last step of the accumulator.
   assert property (@(posedge clock) disable iff (reset)
      solve_start |-> ((state_ff == rcc_pkg::TS_IDLE) || accum_done))
      else $error("solver started on unfinished sums");

endmodule
`default_nettype wire

>>> design/rcc_alu.sv
`default_nettype none
module rcc_alu (
   input  logic [rcc_pkg::WIDE_W-1:0] a,
   input  logic [rcc_pkg::WIDE_W-1:0] b,
   input  logic                       sub,
   output logic [rcc_pkg::WIDE_W-1:0] sum,
   output logic                       carry
);

   localparam int W = rcc_pkg::WIDE_W;
   localparam int W1 = W + 1;

   logic [W:0] full;

   // With sub high, carry is set when a >= b (unsigned).
   assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + W1'(sub);
   assign sum = full[W-1:0];
   assign carry = full[W];

endmodule
`default_nettype wire

>>> design/rcc_accum.sv
`default_nettype none
module rcc_accum #(
   parameter int MAX_SERIES_LOG2 = rcc_pkg::MAX_SERIES_LOG2_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                clear,
   input  logic signed [rcc_pkg::SAMPLE_W-1:0] dep_sample,
   input  logic signed [rcc_pkg::SAMPLE_W-1:0] indep_sample,
   output logic                                done,
   output rcc_pkg::rcc_sums_type               sums
);

   localparam int CW = rcc_pkg::CNT_W;
   localparam int SW = rcc_pkg::SUM_W;
   localparam logic [CW-1:0] CNT_CAP = (MAX_SERIES_LOG2 >= CW) ? {CW{1'b1}} :
                                       CW'(64'd1 << MAX_SERIES_LOG2);
   localparam logic [1:0] STEP_XY = 2'd0;
   localparam logic [1:0] STEP_XX = 2'd1;
   localparam logic [1:0] STEP_YY = 2'd2;
   localparam logic [1:0] STEP_LAST = 2'd3;

   logic busy_ff, busy_in;
   logic [1:0] step_ff, step_in;
   logic signed [rcc_pkg::SAMPLE_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] prod_ff, prod_in;
   rcc_pkg::rcc_sums_type sums_ff, sums_in;

   logic signed [rcc_pkg::SAMPLE_W-1:0] mul_a, mul_b;
   logic [SW+1:0] add_a, add_sum;
   logic xy_ovf, sq_ovf;
   logic [SW-1:0] sxy_sat, sq_sat;

   // One multiplier serves the three products, one adder the three sums.
   always_comb begin
      mul_a = (step_ff == STEP_YY) ? y_ff : x_ff;
      mul_b = (step_ff == STEP_XX) ? x_ff : y_ff;
      prod_in = mul_a * mul_b;
      case (step_ff)
         STEP_XX: add_a = {{2{sums_ff.sxy[SW-1]}}, sums_ff.sxy};
         STEP_YY: add_a = {2'b00, sums_ff.sxx};
         default: add_a = {2'b00, sums_ff.syy};
      endcase
      add_sum = add_a + {{(SW-30){prod_ff[31]}}, prod_ff};
      xy_ovf = !((add_sum[SW+1:SW-1] == 3'b000) || (add_sum[SW+1:SW-1] == 3'b111));
      sq_ovf = (add_sum[SW+1:SW] != 2'b00);
      if (xy_ovf) begin
         sxy_sat = add_sum[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sxy_sat = add_sum[SW-1:0];
      end
      sq_sat = sq_ovf ? {SW{1'b1}} : add_sum[SW-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      x_in = x_ff;
      y_in = y_ff;
      sums_in = sums_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_XY;
         x_in = indep_sample;
         y_in = dep_sample;
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
      if (clear) begin
         sums_in = '0;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_XX: begin
               sums_in.sxy = sxy_sat;
               sums_in.ovf = sums_ff.ovf | xy_ovf;
            end
            STEP_YY: begin
               sums_in.sxx = sq_sat;
               sums_in.ovf = sums_ff.ovf | sq_ovf;
            end
            STEP_LAST: begin
               sums_in.syy = sq_sat;
               if (sums_ff.cnt < CNT_CAP) begin
                  sums_in.cnt = sums_ff.cnt + 1'b1;
                  sums_in.ovf = sums_ff.ovf | sq_ovf;
               end else begin
                  sums_in.ovf = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      prod_ff <= prod_in;
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_XY;
         sums_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         sums_ff <= sums_in;
      end
   end

   assign done = busy_ff && (step_ff == STEP_LAST);
   assign sums = sums_ff;

endmodule
`default_nettype wire

>>> design/rcc_solve.sv
`default_nettype none
module rcc_solve (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               ack,
   input  rcc_pkg::rcc_sums_type              sums,
   input  logic [rcc_pkg::RIDGE_W-1:0]        ridge,
   output logic                               done,
   output logic signed [rcc_pkg::COEF_W-1:0]  coefficient,
   output logic signed [rcc_pkg::CORR_W-1:0]  correlation,
   output logic                               out_sat
);

   localparam int W = rcc_pkg::WIDE_W;
   localparam int SW = rcc_pkg::SUM_W;
   localparam int NW = rcc_pkg::DIV_STEPS;

   rcc_pkg::rcc_solve_state_type state_ff, state_in;

   logic [SW:0] den_ff, den_in;
   logic [SW-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [SW+1:0] rem_ff, rem_in;
   logic [NW-1:0] num_ff, num_in;
   logic [32:0] q_ff, q_in;
   logic big_ff, big_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [SW-1:0] mplier_ff, mplier_in;
   logic [2*SW-1:0] p_ff, p_in;
   logic [2*SW+29:0] r_ff, r_in;
   logic [W-1:0] a_ff, a_in, d_ff, d_in, t_ff, t_in, pb_ff, pb_in;
   logic ok_ff, ok_in;
   logic [rcc_pkg::ROOT_BITS-1:0] m_ff, m_in;
   logic [3:0] bpos_ff, bpos_in;
   logic [rcc_pkg::COEF_W-1:0] coeff_ff, coeff_in;
   logic [rcc_pkg::CORR_W-1:0] corr_ff, corr_in;
   logic csat_ff, csat_in;

   logic [W-1:0] alu_a, alu_b, alu_sum;
   logic alu_sub, alu_carry;
   logic [SW+1:0] shifted;
   logic [32:0] mq;

   rcc_alu u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   assign shifted = {rem_ff[SW:0], num_ff[NW-1]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcc_pkg::SV_IDLE: if (start) state_in = rcc_pkg::SV_DEN;
         rcc_pkg::SV_DEN: state_in = rcc_pkg::SV_DIV;
         rcc_pkg::SV_DIV: begin
            if (cnt_ff == 7'(NW - 1)) state_in = rcc_pkg::SV_COEF;
         end
         rcc_pkg::SV_COEF: state_in = rcc_pkg::SV_MULP;
         rcc_pkg::SV_MULP: begin
            if (cnt_ff == 7'(rcc_pkg::MUL_STEPS - 1)) state_in = rcc_pkg::SV_MULR;
         end
         rcc_pkg::SV_MULR: begin
            if (cnt_ff == 7'(rcc_pkg::MUL_STEPS - 1)) state_in = rcc_pkg::SV_ADDD;
         end
         rcc_pkg::SV_ADDD: state_in = rcc_pkg::SV_ADDP;
         rcc_pkg::SV_ADDP: state_in = rcc_pkg::SV_CMP;
         rcc_pkg::SV_CMP: state_in = rcc_pkg::SV_UPD;
         rcc_pkg::SV_UPD: begin
            state_in = (bpos_ff == 4'd0) ? rcc_pkg::SV_FIN : rcc_pkg::SV_ADDD;
         end
         rcc_pkg::SV_FIN: state_in = rcc_pkg::SV_DONE;
         rcc_pkg::SV_DONE: if (ack) state_in = rcc_pkg::SV_IDLE;
         default: state_in = rcc_pkg::SV_IDLE;
      endcase
   end

   // Operand routing for the shared adder.
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      alu_sub = 1'b0;
      case (state_ff)
         rcc_pkg::SV_DEN: begin
            alu_a = W'(sums.sxx);
            alu_b = W'(ridge);
         end
         rcc_pkg::SV_DIV: begin
            alu_a = W'(shifted);
            alu_b = W'(den_ff);
            alu_sub = 1'b1;
         end
         rcc_pkg::SV_MULP, rcc_pkg::SV_MULR: begin
            alu_a = acc_ff;
            alu_b = mplier_ff[0] ? mcand_ff : '0;
         end
         rcc_pkg::SV_ADDD: begin
            alu_a = a_ff;
            alu_b = d_ff;
         end
         rcc_pkg::SV_ADDP: begin
            alu_a = t_ff;
            alu_b = pb_ff;
         end
         rcc_pkg::SV_CMP: begin
            alu_a = W'(r_ff);
            alu_b = t_ff;
            alu_sub = 1'b1;
         end
         rcc_pkg::SV_UPD: begin
            alu_a = d_ff >> 1;
            alu_b = ok_ff ? pb_ff : '0;
         end
         default: begin
         end
      endcase
      done = (state_ff == rcc_pkg::SV_DONE);
   end

   always_comb begin
      mq = (big_ff | q_ff[32]) ? {1'b1, 32'd0} : q_ff;
      den_in = den_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      q_in = q_ff;
      big_in = big_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      p_in = p_ff;
      r_in = r_ff;
      a_in = a_ff;
      d_in = d_ff;
      t_in = t_ff;
      pb_in = pb_ff;
      ok_in = ok_ff;
      m_in = m_ff;
      bpos_in = bpos_ff;
      coeff_in = coeff_ff;
      corr_in = corr_ff;
      csat_in = csat_ff;
      case (state_ff)
         rcc_pkg::SV_IDLE: begin
            if (start) begin
               neg_in = sums.sxy[SW-1];
               mag_in = sums.sxy[SW-1] ? unsigned'(-sums.sxy) : unsigned'(sums.sxy);
            end
         end
         rcc_pkg::SV_DEN: begin
            den_in = alu_sum[SW:0];
            num_in = {mag_ff, 16'd0};
            rem_in = '0;
            q_in = '0;
            big_in = 1'b0;
            cnt_in = '0;
         end
         rcc_pkg::SV_DIV: begin
            rem_in = alu_carry ? alu_sum[SW+1:0] : shifted;
            q_in = {q_ff[31:0], alu_carry};
            big_in = big_ff | q_ff[32];
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 7'd1;
         end
         rcc_pkg::SV_COEF: begin
            csat_in = 1'b0;
            if (den_ff == '0) begin
               coeff_in = '0;
            end else if (!neg_ff && (mq > 33'h0_7FFF_FFFF)) begin
               coeff_in = 32'h7FFF_FFFF;
               csat_in = 1'b1;
            end else if (neg_ff && (mq > 33'h0_8000_0000)) begin
               coeff_in = 32'h8000_0000;
               csat_in = 1'b1;
            end else begin
               coeff_in = neg_ff ? (32'd0 - mq[31:0]) : mq[31:0];
            end
            acc_in = '0;
            mcand_in = W'(sums.sxx);
            mplier_in = sums.syy;
            cnt_in = '0;
         end
         rcc_pkg::SV_MULP, rcc_pkg::SV_MULR: begin
            acc_in = alu_sum;
            mcand_in = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(rcc_pkg::MUL_STEPS - 1)) begin
               cnt_in = '0;
               acc_in = '0;
               if (state_ff == rcc_pkg::SV_MULP) begin
                  p_in = alu_sum[2*SW-1:0];
                  mcand_in = W'(mag_ff);
                  mplier_in = mag_ff;
               end else begin
                  // Right side of the root search: |sxy|^2 scaled by 2^30.
                  r_in = {alu_sum[2*SW-1:0], 30'd0};
                  a_in = '0;
                  d_in = '0;
                  pb_in = W'({p_ff, 30'd0});
                  m_in = '0;
                  bpos_in = 4'(rcc_pkg::ROOT_BITS - 1);
               end
            end
         end
         rcc_pkg::SV_ADDD, rcc_pkg::SV_ADDP: begin
            t_in = alu_sum;
         end
         rcc_pkg::SV_CMP: begin
            ok_in = alu_carry;
            if (alu_carry) begin
               a_in = t_ff;
               m_in = m_ff | (16'd1 << bpos_ff);
            end
         end
         rcc_pkg::SV_UPD: begin
            d_in = alu_sum;
            pb_in = pb_ff >> 2;
            bpos_in = bpos_ff - 4'd1;
         end
         rcc_pkg::SV_FIN: begin
            if ((sums.sxx == '0) || (sums.syy == '0)) begin
               corr_in = '0;
            end else if (!neg_ff && (m_ff > 16'd32767)) begin
               corr_in = 16'h7FFF;
               csat_in = 1'b1;
            end else if (neg_ff && (m_ff > 16'd32768)) begin
               corr_in = 16'h8000;
               csat_in = 1'b1;
            end else begin
               corr_in = neg_ff ? (16'd0 - m_ff) : m_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      q_ff <= q_in;
      big_ff <= big_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      p_ff <= p_in;
      r_ff <= r_in;
      a_ff <= a_in;
      d_ff <= d_in;
      t_ff <= t_in;
      pb_ff <= pb_in;
      ok_ff <= ok_in;
      m_ff <= m_in;
      bpos_ff <= bpos_in;
      coeff_ff <= coeff_in;
      corr_ff <= corr_in;
      csat_ff <= csat_in;
      if (reset) begin
         state_ff <= rcc_pkg::SV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign coefficient = coeff_ff;
   assign correlation = corr_ff;
   assign out_sat = csat_ff;

endmodule
`default_nettype wire
